@@ hw/rtl/kvbt_pkg.sv @@
// kvbt_pkg: shared sizes, opcodes, entry layout and controller/datapath structs
// for the key/value bucket table. no dependencies.
`default_nettype none

package kvbt_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_BYTES = 8;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SLOT_W    = 6;
  localparam int KEY_W     = 64;
  localparam int KLEN_W    = 4;
  localparam int VAL_W     = 64;
  localparam int OP_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND         = 3'd0,
    OP_SWAP_REMOVE    = 3'd1,
    OP_ORDERED_REMOVE = 3'd2,
    OP_READ           = 3'd3,
    OP_FIND           = 3'd4,
    OP_SIZE           = 3'd5
  } op_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [KLEN_W-1:0] klen;
    logic [VAL_W-1:0]  value;
  } entry_t;

  typedef struct packed {
    logic capture;  // take an input word, set up the walk
    logic walk;     // step the memory walk
    logic commit;   // update count, load the result register
  } kvbt_cmd_t;

  typedef struct packed {
    logic done;     // walk finished or first match found
  } kvbt_stat_t;

  // bytes at or above len (capped at KEY_BYTES) take no part in a compare
  function automatic logic [KEY_W-1:0] key_mask(input logic [KLEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (b < int'(len)) begin
        m[b*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/kvbt_ctrl.sv @@
// kvbt_ctrl: sequencer for the bucket table (idle, walk, respond) and the
// output word valid flag. depends on kvbt_pkg.
`default_nettype none

module kvbt_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  output kvbt_pkg::kvbt_cmd_t  cmd,
  input  kvbt_pkg::kvbt_stat_t stat
);
  import kvbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        // hold the finished word until the result register is free
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/kvbt_dp.sv @@
// kvbt_dp: entry memory, entry count, walk pointer, key compare and result
// register of the bucket table. depends on kvbt_pkg.
`default_nettype none

module kvbt_dp (
  input  wire                                clk,
  input  wire                                rst,
  input  kvbt_pkg::kvbt_cmd_t                cmd,
  output kvbt_pkg::kvbt_stat_t               stat,
  input  wire [kvbt_pkg::OP_W-1:0]           opcode,
  input  wire [kvbt_pkg::KEY_W-1:0]          key_bytes,
  input  wire [kvbt_pkg::KLEN_W-1:0]         key_len,
  input  wire [kvbt_pkg::VAL_W-1:0]          value_in,
  input  wire [kvbt_pkg::SLOT_W-1:0]         slot,
  output logic                               ok,
  output logic [kvbt_pkg::VAL_W-1:0]         value_out,
  output logic [kvbt_pkg::SLOT_W-1:0]        found_slot,
  output logic [kvbt_pkg::CNT_W-1:0]         count
);
  import kvbt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data;
  entry_t wr_data;

  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic [KLEN_W-1:0] len_q;
  logic [VAL_W-1:0]  val_q;
  logic [SLOT_W-1:0] slot_q;
  logic              slot_ok_q;

  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] ptr, lim, ptr_init, lim_init;
  logic [CNT_W-1:0] rd_idx, hit_idx;
  logic             rd_vld, hit;
  logic [VAL_W-1:0] hit_value;

  logic             in_slot_ok;
  logic             not_full;
  logic             rd_en;
  logic             match;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             ok_next;

  assign in_slot_ok = CNT_W'(slot) < cnt;
  assign not_full   = cnt < CNT_W'(DEPTH);
  assign rd_en      = cmd.walk && (ptr < lim) && !hit;

  assign match = (op_q == OP_READ) ||
                 ((op_q == OP_FIND) && (rd_data.klen == len_q) &&
                  (((rd_data.key ^ key_q) & key_mask(len_q)) == '0));

  // done once the first match is held, or every issued read has come back
  assign stat.done = hit || (!rd_vld && !(ptr < lim));

  // walk range: entries [ptr, lim) get read one per cycle
  always_comb begin
    ptr_init = '0;
    lim_init = '0;
    case (opcode)
      OP_FIND: begin
        lim_init = cnt;
      end
      OP_READ: begin
        if (in_slot_ok) begin
          ptr_init = CNT_W'(slot);
          lim_init = CNT_W'(slot) + CNT_W'(1);
        end
      end
      OP_SWAP_REMOVE: begin
        if (in_slot_ok) begin
          ptr_init = cnt - CNT_W'(1);
          lim_init = cnt;
        end
      end
      OP_ORDERED_REMOVE: begin
        if (in_slot_ok) begin
          ptr_init = CNT_W'(slot) + CNT_W'(1);
          lim_init = cnt;
        end
      end
      default: begin
        ptr_init = '0;
        lim_init = '0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt[IDX_W-1:0];
    wr_data = '{key: key_q, klen: len_q, value: val_q};
    if (cmd.commit && (op_q == OP_APPEND) && not_full) begin
      wr_en = 1'b1;
    end else if (cmd.walk && rd_vld) begin
      if (op_q == OP_ORDERED_REMOVE) begin
        // entry i+1 moves down to i
        wr_en   = 1'b1;
        wr_addr = IDX_W'(rd_idx - CNT_W'(1));
        wr_data = rd_data;
      end else if (op_q == OP_SWAP_REMOVE) begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(slot_q);
        wr_data = rd_data;
      end
    end
  end

  always_comb begin
    cnt_next = cnt;
    ok_next  = 1'b0;
    case (op_q) inside
      OP_APPEND: begin
        ok_next = not_full;
        if (not_full) begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      OP_SWAP_REMOVE, OP_ORDERED_REMOVE: begin
        ok_next = slot_ok_q;
        if (slot_ok_q) begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      OP_READ: ok_next = slot_ok_q;
      OP_FIND: ok_next = hit;
      OP_SIZE: ok_next = 1'b1;
      default: ok_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[ptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      ptr    <= '0;
      lim    <= '0;
      rd_vld <= 1'b0;
      hit    <= 1'b0;
    end else begin
      if (cmd.capture) begin
        ptr    <= ptr_init;
        lim    <= lim_init;
        rd_vld <= 1'b0;
        hit    <= 1'b0;
      end else if (cmd.walk) begin
        if (rd_en) begin
          ptr <= ptr + CNT_W'(1);
        end
        rd_vld <= rd_en;
        if (rd_vld && !hit && match) begin
          hit <= 1'b1;
        end
      end
      if (cmd.commit) begin
        cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= opcode;
      key_q     <= key_bytes;
      len_q     <= key_len;
      val_q     <= value_in;
      slot_q    <= slot;
      slot_ok_q <= in_slot_ok;
    end
    if (rd_en) begin
      rd_idx <= ptr;
    end
    if (cmd.walk && rd_vld && !hit && match) begin
      hit_idx   <= rd_idx;
      hit_value <= rd_data.value;
    end
    if (cmd.commit) begin
      ok         <= ok_next;
      value_out  <= hit ? hit_value : '0;
      found_slot <= ((op_q == OP_FIND) && hit) ? SLOT_W'(hit_idx) : '0;
      count      <= cnt_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/key_value_bucket_table.sv @@
// key_value_bucket_table: unordered key/value table, one word in, one word out.
// a word that reads no entry (append, size, refused ops) passes straight through the
// walk; otherwise the walk reads entries one per cycle (read and swap remove: one entry;
// ordered remove: those above the slot; find: up to the match). a finished word then
// waits until the output is free. one word at a time: no new word is accepted until
// the last result is committed. reset clears the entry count, not the entry memory.
`default_nettype none

module key_value_bucket_table (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [kvbt_pkg::OP_W-1:0]           opcode,
  input  wire [kvbt_pkg::KEY_W-1:0]          key_bytes,
  input  wire [kvbt_pkg::KLEN_W-1:0]         key_len,
  input  wire [kvbt_pkg::VAL_W-1:0]          value_in,
  input  wire [kvbt_pkg::SLOT_W-1:0]         slot,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               ok,
  output logic [kvbt_pkg::VAL_W-1:0]         value_out,
  output logic [kvbt_pkg::SLOT_W-1:0]        found_slot,
  output logic [kvbt_pkg::CNT_W-1:0]         count
);
  import kvbt_pkg::*;

  kvbt_cmd_t  cmd;
  kvbt_stat_t stat;

  kvbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  kvbt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .opcode     (opcode),
    .key_bytes  (key_bytes),
    .key_len    (key_len),
    .value_in   (value_in),
    .slot       (slot),
    .ok         (ok),
    .value_out  (value_out),
    .found_slot (found_slot),
    .count      (count)
  );

`ifndef ASSERT_OFF
  // a finished word never overwrites one still waiting at the output
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // an accepted word starts its walk in the next cycle
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> cmd.walk)
    else $error("walk did not start after accept");

  // no new word is taken while a walk is running
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> !in_ready)
    else $error("input ready during walk");

  // reported count never exceeds the table depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count <= CNT_W'(DEPTH)))
    else $error("count above depth");
`endif

endmodule

`default_nettype wire

@@ tb/sv/key_value_bucket_table_test.sv @@
// key_value_bucket_table_test: self-checking bench for the key/value bucket table.
// keeps its own copy of the entries and count, predicts one result word per input
// word and checks it in order; depends on kvbt_pkg and key_value_bucket_table only.
`timescale 1ns / 1ps

module key_value_bucket_table_test;
  import kvbt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam int END_WAIT_LIMIT = 50000;

  typedef struct packed {
    logic              ok;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } kv_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    opcode;
  logic [KEY_W-1:0]   key_bytes;
  logic [KLEN_W-1:0]  key_len;
  logic [VAL_W-1:0]   value_in;
  logic [SLOT_W-1:0]  slot;
  logic               out_valid;
  logic               out_ready;
  logic               ok;
  logic [VAL_W-1:0]   value_out;
  logic [SLOT_W-1:0]  found_slot;
  logic [CNT_W-1:0]   count;

  // shadow of the table contents
  logic [KEY_W-1:0]  tbl_key [DEPTH];
  logic [KLEN_W-1:0] tbl_len [DEPTH];
  logic [VAL_W-1:0]  tbl_val [DEPTH];
  int                tbl_count;

  kv_result_t pending_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int n_errors;
  int n_results;
  int n_words;
  int n_find_hits;
  int n_refused_appends;
  int peak_count;
  int op_seen[8];
  bit last_effective;

  key_value_bucket_table u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .key_bytes  (key_bytes),
    .key_len    (key_len),
    .value_in   (value_in),
    .slot       (slot),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .value_out  (value_out),
    .found_slot (found_slot),
    .count      (count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // bytes at or above the length (capped at KEY_BYTES) are ignored by find
  function automatic logic [KEY_W-1:0] key_window(input logic [KLEN_W-1:0] len);
    int n;
    n = (int'(len) > KEY_BYTES) ? KEY_BYTES : int'(len);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic kv_result_t apply_word(input logic [OP_W-1:0] op,
                                            input logic [KEY_W-1:0] key,
                                            input logic [KLEN_W-1:0] len,
                                            input logic [VAL_W-1:0] val,
                                            input logic [SLOT_W-1:0] idx);
    kv_result_t r;
    logic [KEY_W-1:0] win;
    r = '0;
    win = key_window(len);
    case (op)
      OP_APPEND: begin
        if (tbl_count < DEPTH) begin
          tbl_key[tbl_count] = key;
          tbl_len[tbl_count] = len;
          tbl_val[tbl_count] = val;
          tbl_count++;
          r.ok = 1'b1;
        end
      end
      OP_SWAP_REMOVE: begin
        if (int'(idx) < tbl_count) begin
          tbl_count--;
          tbl_key[idx] = tbl_key[tbl_count];
          tbl_len[idx] = tbl_len[tbl_count];
          tbl_val[idx] = tbl_val[tbl_count];
          r.ok = 1'b1;
        end
      end
      OP_ORDERED_REMOVE: begin
        if (int'(idx) < tbl_count) begin
          tbl_count--;
          for (int i = int'(idx); i < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_len[i] = tbl_len[i+1];
            tbl_val[i] = tbl_val[i+1];
          end
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(idx) < tbl_count) begin
          r.value = tbl_val[idx];
          r.ok = 1'b1;
        end
      end
      OP_FIND: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (!r.ok && tbl_len[i] == len && ((tbl_key[i] ^ key) & win) == '0) begin
            r.ok = 1'b1;
            r.value = tbl_val[i];
            r.slot = SLOT_W'(i);
          end
        end
      end
      OP_SIZE: r.ok = 1'b1;
      default: ;
    endcase
    r.count = CNT_W'(tbl_count);
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KLEN_W-1:0] pick_len();
    // lengths past KEY_BYTES are legal and stored; only KEY_BYTES key bytes are compared
    if ($urandom_range(9) == 0) return KLEN_W'($urandom_range(15, KEY_BYTES + 1));
    return KLEN_W'($urandom_range(KEY_BYTES));
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot(input bit in_range);
    if (in_range && tbl_count > 0) return SLOT_W'($urandom_range(tbl_count - 1));
    if (tbl_count < DEPTH) return SLOT_W'($urandom_range(63, tbl_count));
    return SLOT_W'($urandom_range(63));
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [KLEN_W-1:0] len, input logic [VAL_W-1:0] val,
                           input logic [SLOT_W-1:0] idx);
    kv_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid  = 1'b1;
    opcode    = op;
    key_bytes = key;
    key_len   = len;
    value_in  = val;
    slot      = idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_word(op, key, len, val, idx);
    pending_results.push_back(r);
    n_words++;
    op_seen[op]++;
    if (op == OP_FIND && r.ok) n_find_hits++;
    if (op == OP_APPEND && !r.ok) n_refused_appends++;
    if (tbl_count > peak_count) peak_count = tbl_count;
    last_effective = r.ok || op == OP_FIND;
  endtask

  // sender holds off until every result is back, then idles to let the table drain
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    kv_result_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result word, ok=%0b value_out=%h count=%0d",
                 $time, ok, value_out, count);
      end else begin
        want = pending_results.pop_front();
        check_field("ok", 64'(want.ok), 64'(ok));
        check_field("value_out", want.value, value_out);
        check_field("found_slot", 64'(want.slot), 64'(found_slot));
        check_field("count", 64'(want.count), 64'(count));
      end
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // empty table: everything but append and size is refused
    send_word(OP_SIZE, '0, '0, '0, '0);
    send_word(OP_FIND, '0, 4'd0, '0, '0);
    send_word(OP_READ, '0, '0, '0, 6'd0);
    send_word(OP_SWAP_REMOVE, '0, '0, '0, 6'd0);
    send_word(OP_ORDERED_REMOVE, '0, '0, '0, 6'd63);
    send_word(OP_UNUSED_A, '1, '1, '1, '1);
    send_word(OP_UNUSED_B, '0, '0, '0, '0);
    send_word(OP_APPEND, '0, 4'd0, '0, '0);
    send_word(OP_APPEND, '1, 4'd8, '1, '1);
    send_word(OP_APPEND, 64'h0123_4567_89ab_cdef, 4'd15, 64'hdead_beef_0000_0002, '0);
    send_word(OP_APPEND, 64'h1111_1111_11ab_cdef, 4'd3, 64'h0000_0000_0000_0003, '0);
    send_word(OP_APPEND, 64'h2222_2222_22ab_cdef, 4'd3, 64'h8000_0000_0000_0004, '0);
    // two entries agree in their low three bytes, lowest index must win
    send_word(OP_FIND, 64'h9999_9999_99ab_cdef, 4'd3, '0, '0);
    send_word(OP_FIND, '1, 4'd8, '0, '0);
    send_word(OP_FIND, 64'h0123_4567_89ab_cdef, 4'd15, '0, '0);
    send_word(OP_FIND, 64'h0123_4567_89ab_cdef, 4'd8, '0, '0);
    send_word(OP_FIND, 64'h5a5a_5a5a_5a5a_5a5a, 4'd0, '0, '0);
    send_word(OP_READ, '0, '0, '0, 6'd4);
    send_word(OP_READ, '0, '0, '0, 6'd5);
    send_word(OP_SWAP_REMOVE, '0, '0, '0, 6'd1);
    send_word(OP_FIND, 64'h2222_2222_22ab_cdef, 4'd3, '0, '0);
    send_word(OP_ORDERED_REMOVE, '0, '0, '0, 6'd0);
    send_word(OP_READ, '0, '0, '0, 6'd0);
    send_word(OP_ORDERED_REMOVE, '0, '0, '0, SLOT_W'(tbl_count - 1));
    send_word(OP_SIZE, '0, '0, '0, '0);
  endtask

  task automatic test_full_table();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (tbl_count < DEPTH) send_word(OP_APPEND, rand64(), pick_len(), rand64(), '0);
    send_word(OP_APPEND, rand64(), pick_len(), rand64(), '0);
    send_word(OP_READ, '0, '0, '0, 6'd63);
    send_word(OP_FIND, tbl_key[DEPTH-1], tbl_len[DEPTH-1], '0, '0);
    send_word(OP_ORDERED_REMOVE, '0, '0, '0, 6'd0);
    send_word(OP_SWAP_REMOVE, '0, '0, '0, SLOT_W'(tbl_count - 1));
    while (tbl_count > 0) begin
      send_word($urandom_range(1) ? OP_SWAP_REMOVE : OP_ORDERED_REMOVE,
                rand64(), pick_len(), rand64(), pick_slot(1'b1));
    end
    send_word(OP_SIZE, '0, '0, '0, '0);
  endtask

  // table level swings between empty and full so both ends get exercised
  task automatic test_random_mix(input int n_target, input int idle_pct, input int stall_pct);
    int done_words;
    int r;
    int pick;
    bit filling;
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [KLEN_W-1:0] len;
    logic [VAL_W-1:0]  val;
    logic [SLOT_W-1:0] idx;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    done_words = 0;
    filling = 1'b1;
    while (done_words < n_target) begin
      if (tbl_count >= DEPTH) filling = 1'b0;
      else if (tbl_count <= 1) filling = 1'b1;
      key = rand64();
      len = pick_len();
      val = rand64();
      idx = pick_slot($urandom_range(9) != 0);
      r = $urandom_range(99);
      if (filling) begin
        if (r < 50) op = OP_APPEND;
        else if (r < 57) op = OP_SWAP_REMOVE;
        else if (r < 64) op = OP_ORDERED_REMOVE;
        else if (r < 76) op = OP_READ;
        else if (r < 94) op = OP_FIND;
        else if (r < 98) op = OP_SIZE;
        else op = $urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B;
      end else begin
        if (r < 12) op = OP_APPEND;
        else if (r < 36) op = OP_SWAP_REMOVE;
        else if (r < 56) op = OP_ORDERED_REMOVE;
        else if (r < 70) op = OP_READ;
        else if (r < 92) op = OP_FIND;
        else if (r < 98) op = OP_SIZE;
        else op = $urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B;
      end
      // reuse a stored key with its ignored bytes scrambled
      if (tbl_count > 0 && ((op == OP_FIND && $urandom_range(99) < 65) ||
                            (op == OP_APPEND && $urandom_range(4) == 0))) begin
        pick = $urandom_range(tbl_count - 1);
        len = tbl_len[pick];
        key = tbl_key[pick] ^ (rand64() & ~key_window(len));
      end
      send_word(op, key, len, val, idx);
      if (last_effective) done_words++;
    end
  endtask

  initial begin : main_sequence
    int waited;
    rst       = 1'b1;
    in_valid  = 1'b0;
    opcode    = OP_SIZE;
    key_bytes = '0;
    key_len   = '0;
    value_in  = '0;
    slot      = '0;
    out_ready = 1'b0;
    tbl_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_directed();
    settle();
    test_full_table();
    settle();
    test_random_mix(240, 0, 0);
    settle();
    test_random_mix(240, 70, 0);
    settle();
    test_random_mix(240, 0, 70);
    settle();
    test_random_mix(240, 24, 24);

    @(negedge clk);
    in_valid = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end

    $display("covered %0d words: append %0d, swap remove %0d, ordered remove %0d, read %0d,",
             n_words, op_seen[OP_APPEND], op_seen[OP_SWAP_REMOVE],
             op_seen[OP_ORDERED_REMOVE], op_seen[OP_READ]);
    $display("  find %0d (%0d hits), size %0d, unused %0d, full refusals %0d, peak count %0d",
             op_seen[OP_FIND], n_find_hits, op_seen[OP_SIZE],
             op_seen[OP_UNUSED_A] + op_seen[OP_UNUSED_B], n_refused_appends, peak_count);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
